// File: hdl/tsrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsrp_pkg
// Shared sizes, codes, types and time arithmetic for the timestamp ring and
// pulse repeater.
// ----------------------------------------------------------------------------
package tsrp_pkg;

  localparam int RING_DEPTH   = 512;
  localparam int NUM_CHANNELS = 5;

  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int ADDR_W   = $clog2(NUM_CHANNELS * RING_DEPTH);
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int SEC_W    = 40;
  localparam int NANO_W   = 30;
  localparam int TIME_W   = SEC_W + NANO_W;
  localparam int CYCLE_W  = 27;
  localparam int DSEC_W   = 32;
  localparam int COUNT_W  = 32;

  // Capture path delay and trigger output path delay, in nanoseconds.
  localparam logic [NANO_W-1:0] CAPTURE_LAT = 30'd40;
  localparam logic [NANO_W-1:0] OUTPUT_LAT  = 30'd8;
  localparam logic [NANO_W-1:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [NANO_W:0]   NS_SEC_W    = 31'd1000000000;
  localparam logic [NANO_W:0]   NS_TWO_SEC  = 31'd2000000000;

  // Item functions.
  localparam logic [1:0] FUNC_CAPTURE = 2'd0;
  localparam logic [1:0] FUNC_POP     = 2'd1;
  localparam logic [1:0] FUNC_ARM     = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_DONE    = 3'd0;
  localparam logic [2:0] KIND_STAMP   = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_TRIGGER = 3'd3;
  localparam logic [2:0] KIND_BAD_CH  = 3'd4;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [NANO_W-1:0] nano;
  } time_t;

  // Converts a captured 8 ns cycle count into a stamp taken the capture
  // latency earlier, borrowing or carrying one second as needed.
  function automatic time_t capture_stamp(logic [SEC_W-1:0] sec,
                                          logic [CYCLE_W-1:0] cycles);
    logic [NANO_W-1:0] ns;
    logic [NANO_W-1:0] diff;
    time_t             r;
    ns   = {cycles, 3'b000};
    diff = ns - CAPTURE_LAT;
    if (ns < CAPTURE_LAT) begin
      r.nano = diff + NS_PER_SEC;
      r.sec  = sec - 40'd1;
    end else if (diff >= NS_PER_SEC) begin
      r.nano = diff - NS_PER_SEC;
      r.sec  = sec + 40'd1;
    end else begin
      r.nano = diff;
      r.sec  = sec;
    end
    return r;
  endfunction

  // Adds the repeat period to a setpoint; the nanosecond sum may reach or pass
  // two whole seconds, so up to two seconds are carried.
  function automatic time_t advance(time_t sp, logic [DSEC_W-1:0] psec,
                                    logic [NANO_W-1:0] pnano);
    logic [NANO_W:0] sum;
    logic [1:0]      carry;
    time_t           r;
    sum = {1'b0, sp.nano} + {1'b0, pnano};
    if (sum >= NS_TWO_SEC) begin
      carry  = 2'd2;
      r.nano = NANO_W'(sum - NS_TWO_SEC);
    end else if (sum >= NS_SEC_W) begin
      carry  = 2'd1;
      r.nano = NANO_W'(sum - NS_SEC_W);
    end else begin
      carry  = 2'd0;
      r.nano = sum[NANO_W-1:0];
    end
    r.sec = sp.sec + {{(SEC_W-DSEC_W){1'b0}}, psec} + {{(SEC_W-2){1'b0}}, carry};
    return r;
  endfunction

  // Moves a trigger time earlier by the output latency and normalizes it.
  function automatic time_t cut_latency(time_t t);
    logic [NANO_W-1:0] diff;
    time_t             r;
    diff = t.nano - OUTPUT_LAT;
    if (t.nano < OUTPUT_LAT) begin
      r.nano = diff + NS_PER_SEC;
      r.sec  = t.sec - 40'd1;
    end else if (diff >= NS_PER_SEC) begin
      r.nano = diff - NS_PER_SEC;
      r.sec  = t.sec + 40'd1;
    end else begin
      r.nano = diff;
      r.sec  = t.sec;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/timestamp_ring_pulse_repeater_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_ring_pulse_repeater_unit
// Per-channel timestamp rings with pulse repetition, one item per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// The unit accepts one beat per clock cycle while the output is not stalled
// and returns exactly one result beat for each, in order, through the middle
// stage and the result register. The rate is set by the single-port stamp
// RAM: every item makes at most one access to it (a capture writes one entry,
// a non-empty pop reads one), and its registered read forms the first pipeline stage.
// Channel records (ring pointers, setpoint, period and remaining pulse count)
// live in flip-flops and are updated at the acceptance edge, so a following
// item on the same channel always sees the updated record. The stamp store
// has no reset; it needs none because a pop only reads entries between tail
// and head, and those were all written. A stall on the output holds both
// stages and drops the input ready once the middle stage is full.
// ----------------------------------------------------------------------------
module timestamp_ring_pulse_repeater_unit
  import tsrp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                func_i,
  input  wire logic [2:0]                channel_i,
  input  wire logic [SEC_W-1:0]          seconds_i,
  input  wire logic [NANO_W-1:0]         nanos_i,
  input  wire logic [CYCLE_W-1:0]        cycles_i,
  input  wire logic [DSEC_W-1:0]         delay_seconds_i,
  input  wire logic [NANO_W-1:0]         delay_nanos_i,
  input  wire logic                      loop_enable_i,
  input  wire logic signed [COUNT_W-1:0] repeat_count_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2:0]                     result_kind_o,
  output logic [2:0]                     result_channel_o,
  output logic [SEC_W-1:0]               result_seconds_o,
  output logic [NANO_W-1:0]              result_nanos_o,
  output logic [CYCLE_W-1:0]             trigger_cycle_o
);

  // Middle stage: what the output stage needs to finish the result.
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] channel;
    time_t      base;
  } stage_t;

  // Channel records.
  logic [PTR_W-1:0]   head_q     [NUM_CHANNELS];
  logic [PTR_W-1:0]   tail_q     [NUM_CHANNELS];
  time_t              sp_q       [NUM_CHANNELS];
  logic [DSEC_W-1:0]  per_sec_q  [NUM_CHANNELS];
  logic [NANO_W-1:0]  per_nano_q [NUM_CHANNELS];
  logic [COUNT_W-1:0] pulses_q   [NUM_CHANNELS];

  logic [PTR_W-1:0]   head_d;
  logic [PTR_W-1:0]   tail_d;
  time_t              sp_d;
  logic [DSEC_W-1:0]  per_sec_d;
  logic [NANO_W-1:0]  per_nano_d;
  logic [COUNT_W-1:0] pulses_d;
  logic               chan_we;

  logic               s1_valid_q;
  stage_t             s1_q;
  stage_t             s1_d;

  logic               out_valid_q;
  logic [2:0]         kind_q;
  logic [2:0]         chan_q;
  logic [SEC_W-1:0]   sec_q;
  logic [NANO_W-1:0]  nano_q;
  logic [CYCLE_W-1:0] cycle_q;
  logic [SEC_W-1:0]   sec_d;
  logic [NANO_W-1:0]  nano_d;
  logic [CYCLE_W-1:0] cycle_d;

  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_addr;
  time_t              ram_wdata;
  time_t              ram_rdata;

  logic               in_fire;
  logic               out_free;
  logic               s1_move;
  logic               ch_ok;
  logic [CH_IDX_W-1:0] ci;

  // Handshake: the result register frees up when empty or being taken, and
  // the middle stage frees up when empty or moving on.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ch_ok = ({1'b0, channel_i} < 4'(NUM_CHANNELS));
  assign ci    = channel_i[CH_IDX_W-1:0];

  // Item decode and channel record update.
  always_comb begin
    logic [PTR_W-1:0]  h;
    logic [PTR_W-1:0]  t;
    logic [PTR_W-1:0]  h_inc;
    logic [PTR_W-1:0]  t_inc;
    logic [ADDR_W-1:0] row;
    time_t             adv;
    h     = head_q[ci];
    t     = tail_q[ci];
    h_inc = (h == PTR_W'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
    t_inc = (t == PTR_W'(RING_DEPTH - 1)) ? '0 : t + 1'b1;
    row   = ADDR_W'(ci) * ADDR_W'(RING_DEPTH);
    adv   = advance(sp_q[ci], per_sec_q[ci], per_nano_q[ci]);

    head_d     = h;
    tail_d     = t;
    sp_d       = sp_q[ci];
    per_sec_d  = per_sec_q[ci];
    per_nano_d = per_nano_q[ci];
    pulses_d   = pulses_q[ci];
    chan_we    = 1'b0;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = row + ADDR_W'(h);
    ram_wdata = capture_stamp(seconds_i, cycles_i);

    s1_d.kind      = KIND_DONE;
    s1_d.channel   = channel_i;
    s1_d.base.sec  = seconds_i;
    s1_d.base.nano = nanos_i;

    if (!ch_ok) begin
      s1_d.kind    = KIND_BAD_CH;
      s1_d.channel = 3'd0;
    end else begin
      case (func_i)
        FUNC_CAPTURE: begin
          ram_we  = in_fire;
          chan_we = in_fire;
          head_d  = h_inc;
          // A full ring drops its oldest stamp.
          if (h_inc == t) begin
            tail_d = t_inc;
          end
          if (pulses_q[ci] != '0) begin
            sp_d      = adv;
            s1_d.base = adv;
            s1_d.kind = KIND_TRIGGER;
            if (!pulses_q[ci][COUNT_W-1]) begin
              pulses_d = pulses_q[ci] - 1'b1;
            end
          end
        end
        FUNC_POP: begin
          ram_addr = row + ADDR_W'(t);
          if (t == h) begin
            s1_d.kind = KIND_EMPTY;
          end else begin
            s1_d.kind = KIND_STAMP;
            ram_re    = in_fire;
            chan_we   = in_fire;
            tail_d    = t_inc;
          end
        end
        FUNC_ARM: begin
          s1_d.kind = KIND_TRIGGER;
          if (loop_enable_i) begin
            chan_we    = in_fire;
            sp_d.sec   = seconds_i;
            sp_d.nano  = nanos_i;
            per_sec_d  = delay_seconds_i;
            per_nano_d = delay_nanos_i;
            pulses_d   = repeat_count_i;
            // A positive count already includes this first pulse.
            if (repeat_count_i > 0) begin
              pulses_d = repeat_count_i - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        head_q[i]     <= '0;
        tail_q[i]     <= '0;
        sp_q[i]       <= '0;
        per_sec_q[i]  <= '0;
        per_nano_q[i] <= '0;
        pulses_q[i]   <= '0;
      end
    end else if (chan_we) begin
      head_q[ci]     <= head_d;
      tail_q[ci]     <= tail_d;
      sp_q[ci]       <= sp_d;
      per_sec_q[ci]  <= per_sec_d;
      per_nano_q[ci] <= per_nano_d;
      pulses_q[ci]   <= pulses_d;
    end
  end

  tsrp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_CHANNELS * RING_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Middle stage. The RAM read data lines up with it and holds while it
  // stalls, since a read is only issued when a beat is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // Result formation: stamps come from the RAM, triggers get the output
  // latency cut and their cycle number.
  always_comb begin
    time_t cut;
    cut     = cut_latency(s1_q.base);
    sec_d   = '0;
    nano_d  = '0;
    cycle_d = '0;
    case (s1_q.kind)
      KIND_TRIGGER: begin
        sec_d   = cut.sec;
        nano_d  = cut.nano;
        cycle_d = cut.nano[NANO_W-1:3];
      end
      KIND_STAMP: begin
        sec_d  = ram_rdata.sec;
        nano_d = ram_rdata.nano;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      kind_q  <= s1_q.kind;
      chan_q  <= s1_q.channel;
      sec_q   <= sec_d;
      nano_q  <= nano_d;
      cycle_q <= cycle_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign result_channel_o = chan_q;
  assign result_seconds_o = sec_q;
  assign result_nanos_o   = nano_q;
  assign trigger_cycle_o  = cycle_q;

endmodule
`default_nettype wire

// File: hdl/tsrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsrp_ram
// Generic single-port RAM with one access per cycle and a registered read.
// ----------------------------------------------------------------------------
module tsrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
